>>> design/weighted_point_table_dominance_defines.svh
// Assertion macros for the weighted point table.
// Used by the controller; no other dependencies.
`ifndef WEIGHTED_POINT_TABLE_DOMINANCE_DEFINES_SVH
`define WEIGHTED_POINT_TABLE_DOMINANCE_DEFINES_SVH
`ifndef SYNTH
`define WPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("wpt check failed");
`define WPT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("wpt check failed");
`else
`define WPT_ASSERT(lbl, clk, rst_n, prop)
`define WPT_ASSERT_RST(lbl, clk, prop)
`endif
`endif

>>> design/wptd_pkg.sv
// Shared types and codes for the weighted point table.
// No dependencies.
`default_nettype none
package wptd_pkg;
  localparam int unsigned NDIMS = 4;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_DELETE   = 3'd1;
  localparam logic [2:0] MODE_CONTAINS = 3'd2;
  localparam logic [2:0] MODE_COUNT    = 3'd3;
  localparam logic [2:0] MODE_LIST_GT  = 3'd4;
  localparam logic [2:0] MODE_LIST_LT  = 3'd5;
  localparam logic [2:0] MODE_LIST_BOX = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         weight;
    logic signed [15:0] point0;
    logic signed [15:0] point1;
    logic signed [15:0] point2;
    logic signed [15:0] point3;
    logic signed [15:0] lower0;
    logic signed [15:0] lower1;
    logic signed [15:0] lower2;
    logic signed [15:0] lower3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               present;
    logic [15:0]        dominated_weight;
    logic signed [15:0] match0;
    logic signed [15:0] match1;
    logic signed [15:0] match2;
    logic signed [15:0] match3;
    logic [15:0]        match_weight;
    logic               match_valid;
    logic               last;
    logic               emptied;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the command word
    logic clr_acc;   // clear scan accumulators
    logic rd;        // issue a table read at the scan index
    logic eval;      // evaluate the registered read
    logic rd_last;   // read the last occupied entry (for swap removal)
    logic commit;    // apply insert/delete update
    logic move;      // write last entry into freed slot
    logic emit;      // send the held list match
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sel;       // entry under evaluation is selected for listing
    logic found;     // equality match seen
    logic is_list;
    logic scan_end;  // read index has reached the occupied count
    logic need_move; // delete emptied an entry that is not the last
  } stat_t;
endpackage
`default_nettype wire

>>> design/weighted_point_table_dominance.sv
// Top level of the weighted point table: config register, controller, datapath.
// Depends on wptd_pkg, wptd_ctrl, wptd_datapath.
//
// Use: drive cmd_i and raise start; the word is taken at an edge where start
// is high and busy is low. Every entry in use is read once, one per cycle, from
// a table memory with one read and one write port; a list stops at 16 matches.
// An item passes through the scan, drain, commit, move-read and done states
// before the next can be taken; a delete that moves the last entry into the
// freed slot also passes through the move-write state. One item is worked at
// a time. A single-word result is registered on leaving the commit state.
// Results appear on res_o for one cycle each, marked by res_valid_o, in table
// order for list modes; each match is held until the next one
// or the end of the scan, and the last carries last = 1. The receiver cannot
// stall. Insert, delete, contains, count and mode 7 give one result; a list
// gives one per match (at most 16) or a single empty word.
// cfg_valid_i/cfg_ready_o write dims_in_use (reset 4); write only when idle.
// Reset empties the table at once (occupancy and total cleared); the table
// contents are not cleared.
`default_nettype none
module weighted_point_table_dominance import wptd_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  cmd_i,
  output logic      res_valid_o,
  output out_word_t res_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_data_i
);
  logic [2:0] dims_q;
  cmd_t  cmd;
  stat_t stat;
  out_word_t dp_res;
  logic strobe, last;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dims_q <= 3'd4;
    else if (cfg_valid_i && cfg_ready_o) dims_q <= cfg_data_i;
  end

  wptd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .strobe_o(strobe), .last_o(last)
  );

  wptd_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .cmd_word_i(cmd_i), .dims_i(dims_q), .cmd_i(cmd),
    .stat_o(stat), .res_o(dp_res)
  );

  always_comb begin
    res_o = dp_res;
    res_o.last = last;
  end
  assign res_valid_o = strobe;
endmodule
`default_nettype wire

>>> design/wptd_datapath.sv
// Datapath: entry table memory, scan comparators, accumulators, result register.
// Depends on wptd_pkg.
`default_nettype none
module wptd_datapath import wptd_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IW = $clog2(CAPACITY),
  parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  cmd_word_i,
  input  logic [2:0] dims_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_word_t res_o
);
  logic [NDIMS*16-1:0] coord_mem [CAPACITY];
  logic [15:0]         wt_mem [CAPACITY];

  in_word_t      w_q;
  logic [2:0]    d_q;
  logic [CW-1:0] occ_q, occ_d;
  logic [16:0]   tot_q, tot_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic [IW-1:0] eidx_q;          // index of entry held in rc_q/rw_q
  logic          rvalid_q;
  logic [NDIMS*16-1:0] rc_q;
  logic [15:0]   rw_q;
  logic          found_q;
  logic [IW-1:0] fidx_q;
  logic [15:0]   fw_q;
  logic [16:0]   sum_q;
  logic          need_move_q;
  out_word_t     pend_q, pend_d;  // list match held until the next one or the end

  // coordinates of found entry are kept so a weight-only rewrite is safe
  logic [NDIMS*16-1:0] coord_mem_rd_found;
  logic [NDIMS*16-1:0] fc_q;
  assign coord_mem_rd_found = fc_q;

  logic signed [15:0] q [NDIMS];
  logic signed [15:0] lo [NDIMS];
  logic signed [15:0] c [NDIMS];
  logic eq, gt, lt, box;

  always_comb begin
    q[0] = w_q.point0; q[1] = w_q.point1; q[2] = w_q.point2; q[3] = w_q.point3;
    lo[0] = w_q.lower0; lo[1] = w_q.lower1; lo[2] = w_q.lower2; lo[3] = w_q.lower3;
    for (int j = 0; j < NDIMS; j++) c[j] = rc_q[j*16 +: 16];
    eq = 1'b1; gt = 1'b1; lt = 1'b1; box = 1'b1;
    for (int j = 0; j < NDIMS; j++) begin
      if (3'(j) < d_q) begin
        if (c[j] != q[j]) eq = 1'b0;
        if (c[j] <= q[j]) gt = 1'b0;
        if (c[j] >= q[j]) lt = 1'b0;
        if (c[j] >= q[j] || c[j] < lo[j]) box = 1'b0;
      end
    end
  end

  logic sel;
  always_comb begin
    unique case (w_q.mode)
      MODE_LIST_GT:  sel = gt;
      MODE_LIST_LT:  sel = lt;
      MODE_LIST_BOX: sel = box;
      default:       sel = 1'b0;
    endcase
  end

  logic is_list;
  assign is_list = (w_q.mode == MODE_LIST_GT) || (w_q.mode == MODE_LIST_LT) ||
                   (w_q.mode == MODE_LIST_BOX);

  assign stat_o.sel       = rvalid_q && sel;
  assign stat_o.found     = found_q;
  assign stat_o.is_list   = is_list;
  assign stat_o.scan_end  = (ridx_q >= occ_q);
  assign stat_o.need_move = need_move_q;

  // memory read, registered
  logic [IW-1:0] raddr;
  always_comb begin
    if (cmd_i.rd_last) raddr = IW'(occ_q);
    else               raddr = ridx_q[IW-1:0];
  end
  always_ff @(posedge clk_i) begin
    rc_q   <= coord_mem[raddr];
    rw_q   <= wt_mem[raddr];
    eidx_q <= raddr;
  end

  // commit values
  logic [16:0] nw;
  logic [16:0] tot_add;
  assign nw      = {1'b0, fw_q} + 17'(w_q.weight);
  assign tot_add = tot_q + 17'(w_q.weight);

  logic        wr_en;
  logic [IW-1:0] waddr;
  logic [NDIMS*16-1:0] wc;
  logic [15:0] ww;
  out_word_t   res_d;
  logic        last_is_found;

  always_comb begin
    occ_d = occ_q;
    tot_d = tot_q;
    ridx_d = ridx_q;
    wr_en = 1'b0;
    waddr = fidx_q;
    wc = {w_q.point3, w_q.point2, w_q.point1, w_q.point0};
    ww = 16'(nw);
    res_d = '0;
    last_is_found = (CW'(fidx_q) == occ_q - CW'(1));
    if (cmd_i.clr_acc) ridx_d = '0;
    if (cmd_i.rd) ridx_d = ridx_q + CW'(1);
    if (cmd_i.commit) begin
      res_d.last = 1'b1;
      unique case (w_q.mode)
        MODE_INSERT: begin
          if (w_q.weight == 8'd0) begin
          end else if (found_q) begin
            if (nw > 17'hFFFF || tot_add > 17'hFFFF) res_d.status = ST_OVERFLOW;
            else begin
              wr_en = 1'b1; wc = coord_mem_rd_found; tot_d = tot_add;
            end
          end else if (occ_q >= CW'(CAPACITY)) begin
            res_d.status = ST_FULL;
          end else if (tot_add > 17'hFFFF) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            wr_en = 1'b1; waddr = IW'(occ_q); ww = 16'(w_q.weight);
            occ_d = occ_q + CW'(1); tot_d = tot_add;
          end
        end
        MODE_DELETE: begin
          if (!found_q) res_d.status = ST_MISSING;
          else begin
            if (tot_q != '0) tot_d = tot_q - 17'd1;
            res_d.emptied = (tot_q <= 17'd1);
            if (fw_q == 16'd1) begin
              occ_d = occ_q - CW'(1);
            end else begin
              wr_en = 1'b1; waddr = fidx_q; ww = fw_q - 16'd1;
              wc = coord_mem_rd_found;
            end
          end
        end
        MODE_CONTAINS: res_d.present = found_q;
        MODE_COUNT: res_d.dominated_weight = (sum_q > 17'hFFFF) ? 16'hFFFF : sum_q[15:0];
        default: begin
          // list end and mode 7: empty word
        end
      endcase
    end
    if (cmd_i.move) begin
      wr_en = 1'b1; waddr = fidx_q; wc = rc_q; ww = rw_q;
    end
  end

  always_comb begin
    pend_d = '0;
    pend_d.match_valid = 1'b1;
    pend_d.match_weight = rw_q;
    pend_d.match0 = (d_q > 3'd0) ? c[0] : '0;
    pend_d.match1 = (d_q > 3'd1) ? c[1] : '0;
    pend_d.match2 = (d_q > 3'd2) ? c[2] : '0;
    pend_d.match3 = (d_q > 3'd3) ? c[3] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coord_mem[waddr] <= wc;
      wt_mem[waddr]    <= ww;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      tot_q <= '0;
      ridx_q <= '0;
      rvalid_q <= 1'b0;
      found_q <= 1'b0;
      need_move_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      tot_q <= tot_d;
      ridx_q <= ridx_d;
      rvalid_q <= cmd_i.rd;
      if (cmd_i.clr_acc) found_q <= 1'b0;
      else if (cmd_i.eval && rvalid_q && eq && !found_q) found_q <= 1'b1;
      need_move_q <= cmd_i.commit && (w_q.mode == MODE_DELETE) && found_q &&
                     (fw_q == 16'd1) && !last_is_found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= cmd_word_i;
      d_q <= (dims_i == 3'd0) ? 3'd1 : ((dims_i > 3'(NDIMS)) ? 3'(NDIMS) : dims_i);
    end
    if (cmd_i.clr_acc) sum_q <= '0;
    else if (cmd_i.eval && rvalid_q && lt) begin
      sum_q <= ((sum_q + 17'(rw_q)) > 17'hFFFF) ? 17'h10000 : sum_q + 17'(rw_q);
    end
    if (cmd_i.eval && rvalid_q && eq && !found_q) begin
      fidx_q <= eidx_q; fw_q <= rw_q; fc_q <= rc_q;
    end
    if (cmd_i.eval && rvalid_q && sel) pend_q <= pend_d;
    res_o <= cmd_i.emit ? pend_q : res_d;
  end
endmodule
`default_nettype wire

>>> design/wptd_ctrl.sv
// Controller state machine: scan sequencing, result strobes, busy.
// Depends on wptd_pkg and the assertion macro header.
`default_nettype none
`include "weighted_point_table_dominance_defines.svh"
module wptd_ctrl import wptd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  strobe_o,
  output logic  last_o
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_MOVE_RD, S_MOVE_WR,
                            S_DONE} state_e;
  state_e state_q;
  logic [4:0] nres_q;
  logic strobe_q, last_q;
  logic strobe_d, last_d;

  logic list_hit;
  assign list_hit = ((state_q == S_SCAN) || (state_q == S_DRAIN)) && stat_i.sel &&
                    stat_i.is_list;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && start_i;
    cmd_o.clr_acc = cmd_o.load;
    cmd_o.rd = (state_q == S_SCAN) && !stat_i.scan_end;
    cmd_o.eval = (state_q == S_SCAN) || (state_q == S_DRAIN);
    cmd_o.commit = (state_q == S_COMMIT);
    cmd_o.rd_last = (state_q == S_MOVE_RD);
    cmd_o.move = (state_q == S_MOVE_WR);
    // a held match goes out when the next one turns up, or at commit as the last word
    cmd_o.emit = stat_i.is_list && (nres_q != '0) && (list_hit || (state_q == S_COMMIT));
  end

  assign strobe_d = cmd_o.emit || (state_q == S_COMMIT);
  assign last_d   = (state_q == S_COMMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nres_q <= '0;
      strobe_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
      last_q <= last_d;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          state_q <= S_SCAN; nres_q <= '0;
        end
        S_SCAN, S_DRAIN: begin
          if (list_hit) nres_q <= nres_q + 5'd1;
          if (list_hit && nres_q == 5'(MAX_RESULTS - 1)) state_q <= S_COMMIT;
          else if (state_q == S_DRAIN) state_q <= S_COMMIT;
          else if (stat_i.scan_end) state_q <= S_DRAIN;
        end
        S_COMMIT: state_q <= S_MOVE_RD;
        S_MOVE_RD: state_q <= stat_i.need_move ? S_MOVE_WR : S_DONE;
        S_MOVE_WR: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign last_o = last_q;

  `WPT_ASSERT(a_last_strobe, clk_i, rst_ni, last_q |-> strobe_q)
  `WPT_ASSERT(a_idle_quiet, clk_i, rst_ni, (state_q == S_IDLE) |-> !strobe_q || last_q)
  `WPT_ASSERT(a_one_move, clk_i, rst_ni, cmd_o.move |=> !cmd_o.move)
  `WPT_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> state_q == S_IDLE || !rst_ni)
endmodule
`default_nettype wire
